FILE: rtl/core/prefix_stack_evaluator_assert.svh
// Assertion macros shared by the prefix stack evaluator RTL.
`ifndef PREFIX_STACK_EVALUATOR_ASSERT_SVH
`define PREFIX_STACK_EVALUATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define PSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/pse_pkg.sv
// Package with the types and constants of the prefix stack evaluator.
package pse_pkg;
    localparam int StackDepth = 256;
    localparam int PtrW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);

    localparam logic [2:0] MODE_OPERAND = 3'd0;
    localparam logic [2:0] MODE_ADD = 3'd1;
    localparam logic [2:0] MODE_SUB = 3'd2;
    localparam logic [2:0] MODE_MUL = 3'd3;
    localparam logic [2:0] MODE_DIV = 3'd4;
    localparam logic [2:0] MODE_POW = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;
    localparam logic [1:0] ST_DIVZ = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        logic [30:0] operand_value;
        logic last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0] status;
    } t_out_item;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic start;
        logic [2:0] mode;
    } t_alu_req;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_WAIT, S_START, S_EXEC, S_FINISH, S_OUT
    } t_state;
endpackage

FILE: rtl/core/pse_alu.sv
// Multi-cycle arithmetic unit: add, subtract, multiply, divide and power.
module pse_alu (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pse_pkg::t_alu_req i_req,
    input  logic [31:0]      i_l,
    input  logic [31:0]      i_r,
    output logic             o_done,
    output logic [31:0]      o_result,
    output logic             o_divz
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE, A_DIV, A_POW_MUL, A_POW_SQ, A_DONE
    } t_alu_state;

    t_alu_state r_st, n_st;
    logic [31:0] r_res, n_res;
    logic r_divz, n_divz;
    logic [31:0] r_a, n_a;     // dividend shift or power base
    logic [31:0] r_b, n_b;     // divisor magnitude or exponent
    logic [32:0] r_rem, n_rem;
    logic [5:0] r_cnt, n_cnt;
    logic r_neg, n_neg;
    logic [32:0] w_sub;
    logic [31:0] w_rem_sh;
    logic [31:0] w_mag_l, w_mag_r;

    assign w_mag_l = i_l[31] ? (32'd0 - i_l) : i_l;
    assign w_mag_r = i_r[31] ? (32'd0 - i_r) : i_r;
    assign w_rem_sh = {r_rem[30:0], r_a[31]};
    assign w_sub = {1'b0, w_rem_sh} - {1'b0, r_b};

    // Next-state and datapath of the divide and square-multiply loops.
    always_comb begin
        n_st = r_st;
        n_res = r_res;
        n_divz = r_divz;
        n_a = r_a;
        n_b = r_b;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_neg = r_neg;
        unique case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    n_divz = 1'b0;
                    n_st = A_DONE;
                    unique case (i_req.mode)
                        MODE_ADD: n_res = i_l + i_r;
                        MODE_SUB: n_res = i_l - i_r;
                        MODE_MUL: n_res = i_l * i_r;
                        MODE_DIV: begin
                            if (i_r == 32'd0) begin
                                n_res = 32'd0;
                                n_divz = 1'b1;
                            end else begin
                                n_a = w_mag_l;
                                n_b = w_mag_r;
                                n_rem = 33'd0;
                                n_cnt = 6'd32;
                                n_neg = i_l[31] ^ i_r[31];
                                n_st = A_DIV;
                            end
                        end
                        default: begin
                            if (i_r[31]) begin
                                if (i_l == 32'd1) begin
                                    n_res = 32'd1;
                                end else if (i_l == 32'hFFFF_FFFF) begin
                                    n_res = i_r[0] ? 32'hFFFF_FFFF : 32'd1;
                                end else begin
                                    n_res = 32'd0;
                                end
                            end else begin
                                n_res = 32'd1;
                                n_a = i_l;
                                n_b = i_r;
                                n_st = A_POW_MUL;
                            end
                        end
                    endcase
                end
            end
            A_DIV: begin
                // One quotient bit per cycle, restoring form.
                if (!w_sub[32]) begin
                    n_rem = {1'b0, w_sub[31:0]};
                    n_res = {r_res[30:0], 1'b1};
                end else begin
                    n_rem = {1'b0, w_rem_sh};
                    n_res = {r_res[30:0], 1'b0};
                end
                n_a = {r_a[30:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_st = A_DONE;
                    if (r_neg) begin
                        n_res = 32'd0 - n_res;
                    end
                end
            end
            A_POW_MUL: begin
                if (r_b == 32'd0) begin
                    n_st = A_DONE;
                end else begin
                    if (r_b[0]) begin
                        n_res = r_res * r_a;
                    end
                    n_st = A_POW_SQ;
                end
            end
            A_POW_SQ: begin
                n_a = r_a * r_a;
                n_b = {1'b0, r_b[31:1]};
                n_st = A_POW_MUL;
            end
            default: n_st = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_res <= n_res;
        r_divz <= n_divz;
        r_a <= n_a;
        r_b <= n_b;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_done = (r_st == A_DONE);
    assign o_result = r_res;
    assign o_divz = r_divz;
endmodule

FILE: rtl/core/prefix_stack_evaluator.sv
// Top level of the prefix stack evaluator: stack memory and token sequencer.
// Usage: tokens of a prefix expression arrive right to left on the input
// channel (i_in_valid, o_in_stall, i_in_item). An operand is pushed on a
// 256-entry stack held in a synchronous RAM; an operator pops two entries,
// combines them and pushes the 32-bit result. The token with last set
// produces one transaction on the output channel (o_out_valid, i_out_stall,
// o_out_item) carrying the top of stack and the first error seen.
// Timing: one token at a time; the input stalls until a token is done.
// An operand is written to the stack directly. Add, subtract and multiply go
// straight to done in the arithmetic unit, divide makes one quotient bit per
// cycle there unless the divisor is zero, and power does one multiply and one
// square step per exponent bit unless the exponent is negative. A last token
// adds a stack readout.
// Reset clears the stack count, the status and all control; the stack RAM
// is not cleared and needs no clearing pass.
// While the receiver stalls, the result is held in the output register and
// tokens are still accepted; a further last token waits before its readout
// until the output register is free, and no token is accepted meanwhile.
module prefix_stack_evaluator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pse_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pse_pkg::t_out_item   o_out_item
);
    import pse_pkg::*;

    logic [31:0] r_mem [StackDepth];
    logic [31:0] r_rd_data;
    logic [PtrW-1:0] w_rd_addr, w_wr_addr;
    logic w_wr_en;
    logic [31:0] w_wr_data;

    t_state r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [1:0] r_status, n_status;
    t_in_item r_tok;
    logic [31:0] r_l, n_l;
    logic r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    t_alu_req w_req;
    logic w_alu_done, w_alu_divz;
    logic [31:0] w_alu_res;
    logic w_accept;
    logic w_is_op;
    logic [CntW-1:0] w_cnt_dec;

    assign w_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_is_op = (r_tok.mode != MODE_OPERAND) && (r_tok.mode <= MODE_POW);
    assign w_cnt_dec = r_cnt - CntW'(1);

    // Stack RAM with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    pse_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_l      (r_l),
        .i_r      (r_rd_data),
        .o_done   (w_alu_done),
        .o_result (w_alu_res),
        .o_divz   (w_alu_divz)
    );

    // Next-state logic of the token sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_READ;
            S_READ: begin
                if (w_is_op && r_cnt >= CntW'(2)) begin
                    n_state = S_WAIT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_WAIT: n_state = S_START;
            S_START: n_state = S_EXEC;
            S_EXEC: if (w_alu_done) n_state = S_FINISH;
            S_FINISH: begin
                // A readout waits until the output register is free.
                if (!r_tok.last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls of the token sequencer.
    always_comb begin
        n_cnt = r_cnt;
        n_status = r_status;
        n_l = r_l;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        w_wr_en = 1'b0;
        w_wr_addr = r_cnt[PtrW-1:0];
        w_wr_data = 32'(r_tok.operand_value);
        w_rd_addr = w_cnt_dec[PtrW-1:0];
        w_req = '{start: 1'b0, mode: r_tok.mode};
        unique case (r_state)
            S_READ: begin
                // Top entry is being read; handle operands and underflow here.
                if (r_tok.mode == MODE_OPERAND) begin
                    if (r_cnt >= CntW'(StackDepth)) begin
                        if (r_status == ST_OK) n_status = ST_OVER;
                    end else begin
                        w_wr_en = 1'b1;
                        n_cnt = r_cnt + CntW'(1);
                    end
                end else if (w_is_op && r_cnt < CntW'(2)) begin
                    if (r_status == ST_OK) n_status = ST_UNDER;
                end
            end
            S_WAIT: begin
                n_l = r_rd_data;
                w_rd_addr = PtrW'(r_cnt - CntW'(2));
            end
            S_EXEC: begin
                if (w_alu_done) begin
                    w_wr_en = 1'b1;
                    w_wr_addr = PtrW'(r_cnt - CntW'(2));
                    w_wr_data = w_alu_res;
                    n_cnt = w_cnt_dec;
                    if (w_alu_divz && r_status == ST_OK) n_status = ST_DIVZ;
                end
            end
            S_OUT: begin
                n_out.value = (r_cnt == '0) ? 32'sd0 : r_rd_data;
                n_out.status = (r_cnt == '0 && r_status == ST_OK) ? ST_UNDER : r_status;
                n_out_valid = 1'b1;
                n_cnt = '0;
                n_status = ST_OK;
            end
            default: ;
        endcase
        // Both operands are on hand in the cycle after the second read.
        if (r_state == S_START) begin
            w_req.start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_status <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_status <= n_status;
            r_out_valid <= n_out_valid;
        end
        if (w_accept) begin
            r_tok <= i_in_item;
        end
        r_l <= n_l;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

`include "prefix_stack_evaluator_assert.svh"

    `PSE_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(StackDepth), "stack count beyond depth")
    `PSE_ASSERT_NXT(a_out_clears, i_clk, i_rst_n, r_state == S_OUT, r_cnt == '0 && r_status == ST_OK, "state not cleared after readout")
    `PSE_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !w_accept, "token accepted while busy")
endmodule

FILE: tb/tb_top.sv
// Testbench for the prefix stack evaluator: directed and random token streams checked against a predictor.
module tb_top;
    import pse_pkg::*;

    // Predicts results of token streams and checks each output transaction.
    class expr_scoreboard;
        logic [31:0] stk[StackDepth];
        int unsigned depth_used;
        logic [1:0] err;
        t_out_item pending[$];
        int fails;
        int results_seen;

        function new();
            depth_used = 0;
            err = ST_OK;
            fails = 0;
            results_seen = 0;
        endfunction

        function void note_error(logic [1:0] code);
            if (err == ST_OK) err = code;
        endfunction

        function logic [31:0] ipow(logic [31:0] b, logic [31:0] e);
            logic [31:0] acc;
            acc = 32'd1;
            if (e[31]) begin
                if (b == 32'd1) return 32'd1;
                if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
                return 32'd0;
            end
            while (e != 0) begin
                if (e[0]) acc = acc * b;
                b = b * b;
                e = e >> 1;
            end
            return acc;
        endfunction

        function logic [31:0] apply_op(logic [2:0] m, logic [31:0] l, logic [31:0] r);
            logic [31:0] q;
            logic [31:0] ml;
            logic [31:0] mr;
            case (m)
                MODE_ADD: return l + r;
                MODE_SUB: return l - r;
                MODE_MUL: return l * r;
                MODE_DIV: begin
                    if (r == 0) begin
                        note_error(ST_DIVZ);
                        return 32'd0;
                    end
                    ml = l[31] ? -l : l;
                    mr = r[31] ? -r : r;
                    q = ml / mr;
                    if (l[31] ^ r[31]) q = -q;
                    return q;
                end
                default: return ipow(l, r);
            endcase
        endfunction

        // Note one accepted token.
        function void accept_token(t_in_item it);
            t_out_item res;
            logic [31:0] l;
            logic [31:0] r;
            if (it.mode == MODE_OPERAND) begin
                if (depth_used >= StackDepth) note_error(ST_OVER);
                else begin
                    stk[depth_used] = {1'b0, it.operand_value};
                    depth_used++;
                end
            end else if (it.mode <= MODE_POW) begin
                if (depth_used < 2) note_error(ST_UNDER);
                else begin
                    l = stk[depth_used - 1];
                    r = stk[depth_used - 2];
                    depth_used -= 2;
                    stk[depth_used] = apply_op(it.mode, l, r);
                    depth_used++;
                end
            end
            if (it.last) begin
                res.value = 0;
                if (depth_used == 0) note_error(ST_UNDER);
                else res.value = stk[depth_used - 1];
                res.status = err;
                pending.push_back(res);
                depth_used = 0;
                err = ST_OK;
            end
        endfunction

        // Compare one output transaction with the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item exp_item;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result value=%0d status=%0d", got.value, got.status);
                fails++;
                return;
            end
            exp_item = pending.pop_front();
            if (got.value !== exp_item.value) begin
                $error("value: expected %0d actual %0d", exp_item.value, got.value);
                fails++;
            end
            if (got.status !== exp_item.status) begin
                $error("status: expected %0d actual %0d", exp_item.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;

    expr_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int unsigned cycles = 0;
    int tokens_sent = 0;

    always #6 i_clk = ~i_clk;

    prefix_stack_evaluator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_in_valid && !o_in_stall) sb.accept_token(i_in_item);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
    end

    // Receiver stall pattern, changed at the falling edge.
    always @(negedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycles > 2_000_000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Offer one token and wait until it is accepted.
    task automatic send_token(logic [2:0] m, logic [30:0] v, logic lst);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_item <= '{mode: m, operand_value: v, last: lst};
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tokens_sent++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [30:0] rand_operand();
        case ($urandom_range(5))
            0: return 31'd0;
            1: return 31'($urandom_range(3));
            2: return 31'h7FFF_FFFF;
            3: return 31'($urandom_range(40));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        return 3'($urandom_range(MODE_POW, MODE_ADD));
    endfunction

    // One well-formed expression of n operands with random operators.
    task automatic send_expression(int n);
        int on_stack;
        int left;
        on_stack = 0;
        left = n;
        while (left > 0 || on_stack > 1) begin
            if (left > 0 && (on_stack < 2 || $urandom_range(1))) begin
                send_token(MODE_OPERAND, rand_operand(), (left == 1 && on_stack == 0));
                left--;
                on_stack++;
            end else begin
                send_token(rand_op(), 31'($urandom), (left == 0 && on_stack == 2));
                on_stack--;
            end
        end
    endtask

    // Malformed or noisy token sequences.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) send_token(3'($urandom), 31'($urandom), 1'b0);
        send_token(3'($urandom), 31'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int exprs);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (exprs) begin
            if ($urandom_range(9) < 8) send_expression($urandom_range(1, 4));
            else send_noise();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each operator, divide corners, power corners, status cases.
        send_token(MODE_OPERAND, 31'd5, 1'b0); send_token(MODE_OPERAND, 31'd7, 1'b0);
        send_token(MODE_ADD, 31'd0, 1'b1);
        send_token(MODE_OPERAND, 31'd9, 1'b0); send_token(MODE_OPERAND, 31'd2, 1'b0);
        send_token(MODE_SUB, 31'd0, 1'b1);
        send_token(MODE_OPERAND, 31'h7FFF_FFFF, 1'b0);
        send_token(MODE_OPERAND, 31'h7FFF_FFFF, 1'b0);
        send_token(MODE_MUL, 31'd0, 1'b1);
        send_token(MODE_OPERAND, 31'd0, 1'b0); send_token(MODE_OPERAND, 31'd7, 1'b0);
        send_token(MODE_DIV, 31'd0, 1'b1);
        send_token(MODE_OPERAND, 31'd0, 1'b0); send_token(MODE_OPERAND, 31'd0, 1'b0);
        send_token(MODE_POW, 31'd0, 1'b1);
        // Negative exponent: (0 - 3) as exponent, base 2.
        send_token(MODE_OPERAND, 31'd3, 1'b0); send_token(MODE_OPERAND, 31'd0, 1'b0);
        send_token(MODE_SUB, 31'd0, 1'b0); send_token(MODE_OPERAND, 31'd2, 1'b0);
        send_token(MODE_POW, 31'd0, 1'b1);
        send_token(MODE_ADD, 31'd0, 1'b1);
        send_token(3'd6, 31'h7FFF_FFFF, 1'b0); send_token(3'd7, 31'd0, 1'b1);
        wait_drained();

        // Overflow: fill past the stack depth.
        repeat (StackDepth + 2) send_token(MODE_OPERAND, 31'($urandom), 1'b0);
        send_token(MODE_ADD, 31'd0, 1'b1);
        wait_drained();

        // Back-pressure: receiver holds off while tokens keep coming.
        hold_off = 1'b1;
        fork
            run_phase(0, 0, 6);
            begin
                repeat (600) @(posedge i_clk);
                @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();

        run_phase(0, 0, 40);
        run_phase(50, 0, 40);
        run_phase(0, 50, 40);
        run_phase(23, 23, 40);
        send_idle_pct = 0;
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("Sent %0d tokens, checked %0d results, incl. overflow, underflow,",
                 tokens_sent, sb.results_seen);
        $display("divide-by-zero, unused modes, a long output hold-off and idle mixes.");
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pse_pkg.sv
rtl/core/pse_alu.sv
rtl/core/prefix_stack_evaluator.sv
tb/tb_top.sv
